// ===== hdl/lzw_stream_compressor_defines.svh =====
// ----------------------------------------------------------------------------
// lzw_stream_compressor_defines.svh
// Assertion macros shared by the checking code of the LZW compressor.
// ----------------------------------------------------------------------------
`ifndef LZW_STREAM_COMPRESSOR_DEFINES_SVH
`define LZW_STREAM_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LZW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LZW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw_pkg
// Widths and shared types of the LZW stream compressor.
// ----------------------------------------------------------------------------
package lzw_pkg;

  // Code and counter widths
  localparam int CODE_W     = 12;
  localparam int CNT_W      = 13;
  localparam int SC_W       = 9;
  localparam int SYM_W      = 8;
  localparam int CODE_SPACE = 4096;

  // One code handed to the output register
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              eos;
  } emit_t;

endpackage

// ===== hdl/lzw_sym_if.sv =====
// ----------------------------------------------------------------------------
// lzw_sym_if
// Symbol channel: one input symbol and its last marker per item.
// ----------------------------------------------------------------------------
interface lzw_sym_if;
  logic                      valid;
  logic                      ready;
  logic [lzw_pkg::SYM_W-1:0] symbol;
  logic                      last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== hdl/lzw_code_if.sv =====
// ----------------------------------------------------------------------------
// lzw_code_if
// Code channel: one emitted code and its end-of-stream flag per item.
// ----------------------------------------------------------------------------
interface lzw_code_if;
  logic                       valid;
  logic                       ready;
  logic [lzw_pkg::CODE_W-1:0] out_code;
  logic                       end_of_stream;

  modport source (output valid, output out_code, output end_of_stream, input ready);
  modport sink (input valid, input out_code, input end_of_stream, output ready);
endinterface

// ===== hdl/lzw_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lzw_cfg_if
// Configuration write channel carrying the symbol count register.
// ----------------------------------------------------------------------------
interface lzw_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [lzw_pkg::SC_W-1:0] symbol_count;

  modport source (output valid, output symbol_count, input ready);
  modport sink (input valid, input symbol_count, output ready);
endinterface

// ===== hdl/lzw_ram.sv =====
// ----------------------------------------------------------------------------
// lzw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lzw_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/lzw_out_reg.sv =====
// ----------------------------------------------------------------------------
// lzw_out_reg
// Output register of the code channel; decouples the core from stalls.
// ----------------------------------------------------------------------------
module lzw_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lzw_pkg::emit_t     emit_i,
  output logic               free_o,
  lzw_code_if.source         code_o
);

  logic                       valid_q;
  logic [lzw_pkg::CODE_W-1:0] code_q;
  logic                       eos_q;

  // Slot can take a new code when empty or draining this cycle
  assign free_o = !valid_q || code_o.ready;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.valid && free_o) begin
      valid_q <= 1'b1;
    end else if (code_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (emit_i.valid && free_o) begin
      code_q <= emit_i.code;
      eos_q  <= emit_i.eos;
    end
  end

  assign code_o.valid         = valid_q;
  assign code_o.out_code      = code_q;
  assign code_o.end_of_stream = eos_q;

endmodule

// ===== hdl/lzw_stream_compressor.sv =====
// ----------------------------------------------------------------------------
// lzw_stream_compressor
// GIF-style LZW compressor with a RAM-held dictionary, codes up to 12 bits.
// ----------------------------------------------------------------------------
// One symbol is taken per item, one code is given per result item. Each stream
// opens with the clear code (symbol_count) and closes with the end code
// (symbol_count+1, end_of_stream high) after the item marked last. The
// dictionary sits in one RAM with a registered read and is searched linearly
// over the entries of the running stream, one entry read per cycle, and the
// search stops at the first hit. The next item is taken once the previous
// one is done, even while its last code still waits in the output register.
// symbol_count is clamped to 2..2^SYMBOL_BITS and takes effect when the next
// stream starts. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lzw_stream_compressor #(
  parameter int DICT_ENTRIES = 4096,
  parameter int SYMBOL_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzw_sym_if.sink     sym_i,
  lzw_code_if.source  code_o,
  lzw_cfg_if.sink     cfg_i
);

  localparam int CODE_LIMIT = (DICT_ENTRIES < lzw_pkg::CODE_SPACE) ?
                              DICT_ENTRIES : lzw_pkg::CODE_SPACE;
  localparam int AW    = $clog2(CODE_LIMIT);
  localparam int KEY_W = lzw_pkg::CODE_W + SYMBOL_BITS;
  localparam logic [lzw_pkg::SC_W-1:0]  SC_MAX = lzw_pkg::SC_W'(1 << SYMBOL_BITS);
  localparam logic [lzw_pkg::SC_W-1:0]  SC_MIN = lzw_pkg::SC_W'(2);
  localparam logic [lzw_pkg::CNT_W-1:0] LIMIT  = lzw_pkg::CNT_W'(CODE_LIMIT);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_MISS   = 6'b001000,
    ST_LAST   = 6'b010000,
    ST_EOS    = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  logic [lzw_pkg::SC_W-1:0]    sym_count_q, sym_count_d;
  logic [lzw_pkg::SC_W-1:0]    strm_count_q, strm_count_d;
  logic [lzw_pkg::CNT_W-1:0]   next_free_q, next_free_d;
  logic [lzw_pkg::CODE_W-1:0]  prefix_q, prefix_d;
  logic                        present_q, present_d;
  logic                        started_q, started_d;
  logic [lzw_pkg::CNT_W-1:0]   scan_q, scan_d;
  logic                        pend_q, pend_d;
  logic [lzw_pkg::CODE_W-1:0]  pend_code_q, pend_code_d;
  logic [SYMBOL_BITS-1:0]      sym_q;
  logic                        last_q;

  logic [SYMBOL_BITS-1:0]      sym_in;
  logic                        in_acc;
  logic                        cfg_acc;
  logic [lzw_pkg::SC_W-1:0]    cfg_clamped;
  logic [KEY_W-1:0]            key;
  logic [KEY_W-1:0]            rdata;
  logic                        hit;
  logic                        rd_en;
  logic                        wr_en;
  lzw_pkg::emit_t              emit;
  logic                        out_free;

  assign sym_in      = sym_i.symbol[SYMBOL_BITS-1:0];
  assign sym_i.ready = (state_q == ST_IDLE);
  assign in_acc      = sym_i.valid && sym_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  // Clamp the written count into the legal range
  always_comb begin
    cfg_clamped = cfg_i.symbol_count;
    if (cfg_i.symbol_count < SC_MIN) begin
      cfg_clamped = SC_MIN;
    end else if (cfg_i.symbol_count > SC_MAX) begin
      cfg_clamped = SC_MAX;
    end
  end

  assign key = {prefix_q, sym_q};
  assign hit = pend_q && (rdata == key);

  // Control: accept, search, emit, insert
  always_comb begin
    state_d      = state_q;
    sym_count_d  = sym_count_q;
    strm_count_d = strm_count_q;
    next_free_d  = next_free_q;
    prefix_d     = prefix_q;
    present_d    = present_q;
    started_d    = started_q;
    scan_d       = scan_q;
    pend_d       = 1'b0;
    pend_code_d  = pend_code_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    emit         = '0;

    // Register write; the running stream keeps its latched count
    if (cfg_acc) begin
      sym_count_d = cfg_clamped;
      if (!started_q) begin
        next_free_d = lzw_pkg::CNT_W'(cfg_clamped) + lzw_pkg::CNT_W'(2);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!started_q) begin
            started_d    = 1'b1;
            strm_count_d = sym_count_d;
            next_free_d  = lzw_pkg::CNT_W'(sym_count_d) + lzw_pkg::CNT_W'(2);
            present_d    = 1'b0;
            prefix_d     = '0;
            state_d      = ST_CLEAR;
          end else if (!present_q) begin
            prefix_d  = lzw_pkg::CODE_W'(sym_in);
            present_d = 1'b1;
            state_d   = sym_i.last_symbol ? ST_LAST : ST_IDLE;
          end else begin
            scan_d  = lzw_pkg::CNT_W'(strm_count_q) + lzw_pkg::CNT_W'(2);
            state_d = ST_SEARCH;
          end
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.code  = lzw_pkg::CODE_W'(strm_count_q);
          prefix_d   = lzw_pkg::CODE_W'(sym_q);
          present_d  = 1'b1;
          state_d    = last_q ? ST_LAST : ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          prefix_d = pend_code_q;
          state_d  = last_q ? ST_LAST : ST_IDLE;
        end else if (scan_q < next_free_q) begin
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_code_d = scan_q[lzw_pkg::CODE_W-1:0];
          scan_d      = scan_q + lzw_pkg::CNT_W'(1);
        end else begin
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.code  = prefix_q;
          if (next_free_q < LIMIT) begin
            wr_en       = 1'b1;
            next_free_d = next_free_q + lzw_pkg::CNT_W'(1);
          end
          prefix_d = lzw_pkg::CODE_W'(sym_q);
          state_d  = last_q ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.code  = prefix_q;
          state_d    = ST_EOS;
        end
      end
      ST_EOS: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.code   = lzw_pkg::CODE_W'(strm_count_q) + lzw_pkg::CODE_W'(1);
          emit.eos    = 1'b1;
          started_d   = 1'b0;
          present_d   = 1'b0;
          prefix_d    = '0;
          next_free_d = lzw_pkg::CNT_W'(sym_count_d) + lzw_pkg::CNT_W'(2);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sym_count_q  <= SC_MAX;
      strm_count_q <= SC_MAX;
      next_free_q  <= lzw_pkg::CNT_W'(SC_MAX) + lzw_pkg::CNT_W'(2);
      prefix_q     <= '0;
      present_q    <= 1'b0;
      started_q    <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      sym_count_q  <= sym_count_d;
      strm_count_q <= strm_count_d;
      next_free_q  <= next_free_d;
      prefix_q     <= prefix_d;
      present_q    <= present_d;
      started_q    <= started_d;
      pend_q       <= pend_d;
    end
  end

  // Item payload and scan position
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q  <= sym_in;
      last_q <= sym_i.last_symbol;
    end
    scan_q      <= scan_d;
    pend_code_q <= pend_code_d;
  end

  // Dictionary: one (prefix, symbol) pair per code
  lzw_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CODE_LIMIT)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (next_free_q[AW-1:0]),
    .wdata_i (key),
    .re_i    (rd_en),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Result register
  lzw_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emit_i (emit),
    .free_o (out_free),
    .code_o (code_o)
  );

endmodule

// ===== hdl/lzw_chk.sv =====
// ----------------------------------------------------------------------------
// lzw_chk
// Port-level checks of the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_stream_compressor_defines.svh"

module lzw_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [lzw_pkg::CODE_W-1:0] out_code_i,
  input logic                       out_eos_i,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_i
);

  // Symbols are worked one at a time
  `LZW_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i, "item overlap")

  // End code lies in the legal range
  `LZW_ASSERT_NOW(a_eos_code, out_valid_i && out_eos_i, (out_code_i >= 12'd3) && (out_code_i <= 12'd257), "bad end code")

  // Stalled result holds
  `LZW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_code_i) && $stable(out_eos_i), "result dropped")

  // Register writes never stall
  `LZW_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_i, "config stalled")

endmodule

bind lzw_stream_compressor lzw_chk u_lzw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sym_i.valid),
  .in_ready_i  (sym_i.ready),
  .out_valid_i (code_o.valid),
  .out_ready_i (code_o.ready),
  .out_code_i  (code_o.out_code),
  .out_eos_i   (code_o.end_of_stream),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

// ===== test/lzw_scoreboard.sv =====
// ----------------------------------------------------------------------------
// lzw_scoreboard
// Predicts the codes of the LZW compressor and checks each emitted code.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class lzw_scoreboard;
  typedef struct {
    logic [lzw_pkg::CODE_W-1:0] code;
    logic                       eos;
  } code_t;

  // Dictionary pairs: prefix code in [19:8], symbol in [7:0]
  bit [19:0] dict_pairs [lzw_pkg::CODE_SPACE];
  int unsigned free_code;
  int unsigned prefix_code;
  bit          has_prefix;
  bit          in_stream;
  int unsigned count_reg;
  int unsigned live_count;
  code_t       pending_codes[$];
  int          fail_count;

  function new();
    count_reg   = 256;
    live_count  = 256;
    free_code   = 258;
    prefix_code = 0;
    has_prefix  = 0;
    in_stream   = 0;
    fail_count  = 0;
  endfunction

  // Clamp the written count to 2 .. 256
  function void write_count(logic [lzw_pkg::SC_W-1:0] value);
    int unsigned v;
    v = value;
    if (v < 2) v = 2;
    if (v > 256) v = 256;
    count_reg = v;
    if (!in_stream) free_code = v + 2;
  endfunction

  function void push_code(int unsigned code, bit eos);
    code_t c;
    c.code = code[lzw_pkg::CODE_W-1:0];
    c.eos  = eos;
    pending_codes.push_back(c);
  endfunction

  // Note one accepted symbol and queue the codes it causes
  function void note_symbol(logic [7:0] sym, logic last);
    bit [19:0]   key;
    bit          hit;
    int unsigned idx;
    hit = 0;
    if (!in_stream) begin
      in_stream   = 1;
      live_count  = count_reg;
      free_code   = live_count + 2;
      has_prefix  = 0;
      prefix_code = 0;
      push_code(live_count, 0);
    end
    if (!has_prefix) begin
      prefix_code = sym;
      has_prefix  = 1;
    end else begin
      key = {prefix_code[11:0], sym};
      for (idx = live_count + 2; idx < free_code && idx < 4096; idx++) begin
        if (dict_pairs[idx] == key) begin
          hit = 1;
          break;
        end
      end
      if (hit) begin
        prefix_code = idx;
      end else begin
        push_code(prefix_code, 0);
        if (free_code < 4096) begin
          dict_pairs[free_code] = key;
          free_code++;
        end
        prefix_code = sym;
      end
    end
    if (last) begin
      push_code(prefix_code, 0);
      push_code(live_count + 1, 1);
      in_stream   = 0;
      has_prefix  = 0;
      prefix_code = 0;
      free_code   = count_reg + 2;
    end
  endfunction

  // Compare one emitted code with the oldest expectation
  function void check_code(logic [11:0] code, logic eos);
    code_t exp_c;
    if (pending_codes.size() == 0) begin
      $error("unexpected code %0d eos %0d", code, eos);
      fail_count++;
      return;
    end
    exp_c = pending_codes.pop_front();
    if (code !== exp_c.code) begin
      $error("out_code: expected %0d, actual %0d", exp_c.code, code);
      fail_count++;
    end
    if (eos !== exp_c.eos) begin
      $error("end_of_stream: expected %0d, actual %0d", exp_c.eos, eos);
      fail_count++;
    end
  endfunction
endclass

// ===== test/tb_lzw_stream_compressor.sv =====
// ----------------------------------------------------------------------------
// tb_lzw_stream_compressor
// Drives symbol streams under several symbol counts and handshake pressures,
// and checks every emitted code against a built-in LZW predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lzw_stream_compressor;
  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;

  lzw_sym_if  sym_if ();
  lzw_code_if code_if ();
  lzw_cfg_if  cfg_if ();

  lzw_scoreboard lzw_board;

  lzw_stream_compressor u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_if.sink),
    .code_o (code_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fail and stop the run after a generous fixed time
  initial begin
    #20ms;
    $display("** lzw_stream_compressor: FAILED **");
    $finish;
  end

  // Drive ready with random stalls and check codes on the rising edge
  initial begin
    code_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && code_if.valid && code_if.ready)
        lzw_board.check_code(code_if.out_code, code_if.end_of_stream);
      @(negedge clk_i);
      code_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one symbol, idling at random before it; valid stays up afterwards
  task automatic send_symbol(logic [7:0] sym, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sym_if.valid       <= 1'b1;
    sym_if.symbol      <= sym;
    sym_if.last_symbol <= last;
    do @(posedge clk_i); while (!sym_if.ready);
    lzw_board.note_symbol(sym, last);
    @(negedge clk_i);
  endtask

  // Write the count register while the block is idle
  task automatic write_count(logic [8:0] value);
    sym_if.valid <= 1'b0;
    while (lzw_board.pending_codes.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.symbol_count <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    lzw_board.write_count(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Send a stream of random symbols below the given bound, with occasional symbols of any value when noisy
  task automatic send_stream(int len, int bound, bit noisy);
    logic [7:0] sym;
    for (int i = 0; i < len; i++) begin
      sym = 8'($urandom_range(bound - 1));
      if (noisy && $urandom_range(9) == 0) sym = 8'($urandom_range(255));
      send_symbol(sym, i == len - 1);
    end
  endtask

  // Run one pressure phase of random streams
  task automatic run_phase(int idle_pct, int stall_pct, int n_items, int count);
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 30);
      send_stream(len, (count > 4 && $urandom_range(1)) ? 4 : count, 1);
      sent += len;
    end
  endtask

  initial begin
    lzw_board          = new();
    rst_ni             = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    sym_if.valid       = 1'b0;
    sym_if.symbol      = '0;
    sym_if.last_symbol = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.symbol_count = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, repeats for dictionary hits, single-symbol stream
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b0);
    send_symbol(8'd0, 1'b1);
    send_symbol(8'd170, 1'b1);
    // Clamp low, symbol above count, clamp high
    write_count(9'd0);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd200, 1'b0);
    send_symbol(8'd85, 1'b1);
    write_count(9'd511);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd1, 1'b1);
    write_count(9'd2);

    run_phase(0, 0, 90, 2);
    write_count(9'd256);
    run_phase(50, 0, 90, 256);
    write_count(9'd17);
    run_phase(0, 50, 90, 17);
    write_count(9'd3);
    run_phase(9, 9, 80, 3);

    // Close with a short stream on two symbols
    write_count(9'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_stream(20, 2, 0);

    sym_if.valid <= 1'b0;
    while (lzw_board.pending_codes.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (lzw_board.fail_count == 0) begin
      $display("** lzw_stream_compressor: PASSED **");
    end else begin
      $display("** lzw_stream_compressor: FAILED **");
    end
    $finish;
  end
endmodule

// ===== lzw_stream_compressor.f =====
+incdir+hdl
hdl/lzw_pkg.sv
hdl/lzw_sym_if.sv
hdl/lzw_code_if.sv
hdl/lzw_cfg_if.sv
hdl/lzw_ram.sv
hdl/lzw_out_reg.sv
hdl/lzw_stream_compressor.sv
hdl/lzw_chk.sv
test/lzw_scoreboard.sv
test/tb_lzw_stream_compressor.sv
